// File: rtl/lsmq_pkg.sv
// lsmq_pkg: shared constants and types for the line set max query tree core
// no dependencies
package lsmq_pkg;

    localparam int MAX_COORDS_DEF = 1024;

    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] S64_MIN = -64'sh7FFF_FFFF_FFFF_FFFF - 64'sd1;

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b0000000001,
        ST_CLEAR = 10'b0000000010,
        ST_NODE  = 10'b0000000100,
        ST_XADDR = 10'b0000001000,
        ST_XWAIT = 10'b0000010000,
        ST_MUL   = 10'b0000100000,
        ST_ADD   = 10'b0001000000,
        ST_CMP   = 10'b0010000000,
        ST_WRITE = 10'b0100000000,
        ST_OUT   = 10'b1000000000
    } state_t;

    // saturating Q32.32 add of product and intercept
    function automatic logic signed [63:0] sat_add(input logic signed [63:0] p,
                                                   input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {p[63], p} + {b[63], b};
        if (s[64] != s[63])
            sat_add = s[64] ? S64_MIN : S64_MAX;
        else
            sat_add = s[63:0];
    endfunction

endpackage

// File: rtl/line_set_max_query_tree_core.sv
// line_set_max_query_tree_core: li chao max tree with coordinate table and node store
// depends on lsmq_pkg; reset loads the count with MAX_COORDS, then a clearing pass over
// 2^(clog2(MAX_COORDS)+1) node entries (2048 by default) zeroes them, no transaction taken
// load and unused op: taken without leaving idle; query: node, xaddr, xwait, mul and add
// states per tree level, then out; insert: mid test, then lo and hi tests as needed, then
// write at each inner level, mid test and write at a leaf; one transaction at a time (shared mul/add)
module line_set_max_query_tree_core #(
    parameter int MAX_COORDS = lsmq_pkg::MAX_COORDS_DEF,
    localparam int IW = $clog2(MAX_COORDS),
    localparam int NW = IW + 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         op,
    input  logic [9:0]         index,
    input  logic signed [31:0] coord_value,
    input  logic signed [31:0] slope,
    input  logic signed [63:0] intercept,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [63:0] max_value,
    input  logic               cfg_we,
    input  logic [10:0]        cfg_wdata
);

    localparam int NODES = 2 ** NW;
    localparam logic [IW:0] MAXC = (IW + 1)'(MAX_COORDS);

    // evaluation point of an insert test
    localparam logic [1:0] PT_MID  = 2'd0;
    localparam logic [1:0] PT_LO   = 2'd1;
    localparam logic [1:0] PT_HI   = 2'd2;
    localparam logic [1:0] PT_DESC = 2'd3;

    // memories
    logic signed [31:0] coord_mem [MAX_COORDS];
    logic signed [31:0] nslope_mem [NODES];
    logic signed [63:0] nicpt_mem [NODES];

    lsmq_pkg::state_t state_reg, state_next;
    logic [10:0] count_reg;

    // walk state
    logic [NW-1:0] node_reg;
    logic [IW-1:0] lo_reg, hi_reg, pos_reg;
    logic [IW-1:0] mid;
    logic [IW-1:0] idx_in;
    logic          is_ins_reg;
    logic signed [31:0] nm_reg;      // carried line
    logic signed [63:0] nb_reg;
    logic signed [31:0] cm_reg;      // node line
    logic signed [63:0] cb_reg;
    logic signed [31:0] nrd_m_reg;   // node store read data
    logic signed [63:0] nrd_b_reg;
    logic signed [31:0] x_reg;
    logic signed [63:0] prod_reg;
    logic signed [63:0] vc_reg, best_reg;
    logic [1:0] step_reg;            // eval point of the current test
    logic       which_reg;           // 0 node line, 1 carried line
    logic       swap_reg;
    logic       cmp_left_reg;        // lo test won, descend left
    logic [NW-1:0] clr_reg;
    logic signed [63:0] out_reg;
    logic       ov_reg;

    // effective count and top index
    logic [IW:0] eff_cnt;
    always_comb
    begin
        if (count_reg == 11'd0)
            eff_cnt = (IW + 1)'(1);
        else if ({{(32-11){1'b0}}, count_reg} > MAX_COORDS)
            eff_cnt = MAXC;
        else
            eff_cnt = (IW + 1)'(count_reg);
    end

    assign mid = IW'(({1'b0, lo_reg} + {1'b0, hi_reg}) >> 1);
    assign idx_in = IW'(index);

    logic [IW-1:0] eval_pos;
    always_comb
    begin
        if (!is_ins_reg)
            eval_pos = pos_reg;
        else if (step_reg == PT_MID)
            eval_pos = mid;
        else if (step_reg == PT_LO)
            eval_pos = lo_reg;
        else
            eval_pos = hi_reg;
    end

    logic [IW-1:0] idx_top;
    assign idx_top = IW'(eff_cnt - (IW + 1)'(1));

    logic signed [63:0] val;
    assign val = lsmq_pkg::sat_add(prod_reg, which_reg ? nb_reg : cb_reg);

    logic leaf;
    assign leaf = (lo_reg == hi_reg);

    assign in_stall  = (state_reg != lsmq_pkg::ST_IDLE) || ov_reg;
    assign out_valid = ov_reg;
    assign max_value = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 11'(MAX_COORDS);
        end
        else if (cfg_we)
        begin
            count_reg <= cfg_wdata;
        end
    end

    // coordinate memory
    always_ff @(posedge clk)
    begin
        if (state_reg == lsmq_pkg::ST_IDLE && in_valid && !in_stall && op == lsmq_pkg::OP_LOAD
            && {22'd0, index} < MAX_COORDS)
            coord_mem[idx_in] <= coord_value;
        if (state_reg == lsmq_pkg::ST_XADDR)
            x_reg <= coord_mem[eval_pos];
    end

    // node memories, one port each
    logic          nwe;
    logic [NW-1:0] nwa;
    logic signed [31:0] nwm;
    logic signed [63:0] nwb;
    always_comb
    begin
        nwe = 1'b0;
        nwa = node_reg;
        nwm = cm_reg;
        nwb = cb_reg;
        if (state_reg == lsmq_pkg::ST_CLEAR)
        begin
            nwe = 1'b1;
            nwa = clr_reg;
            nwm = '0;
            nwb = '0;
        end
        else if (state_reg == lsmq_pkg::ST_WRITE)
        begin
            nwe = swap_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (nwe)
        begin
            nslope_mem[nwa] <= nwm;
            nicpt_mem[nwa]  <= nwb;
        end
        if (state_reg == lsmq_pkg::ST_NODE)
        begin
            nrd_m_reg <= nslope_mem[node_reg];
            nrd_b_reg <= nicpt_mem[node_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lsmq_pkg::ST_CLEAR;
            clr_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == lsmq_pkg::ST_CLEAR)
                clr_reg <= clr_reg + NW'(1);
            if (ov_reg && !out_stall)
                ov_reg <= 1'b0;
            if (state_reg == lsmq_pkg::ST_OUT)
                ov_reg <= 1'b1;
        end
    end

    // sequencer data path
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            lsmq_pkg::ST_IDLE:
            begin
                node_reg   <= NW'(1);
                lo_reg     <= '0;
                hi_reg     <= idx_top;
                pos_reg    <= (idx_in > idx_top || {22'd0, index} >= MAX_COORDS)
                              ? idx_top : idx_in;
                is_ins_reg <= (op == lsmq_pkg::OP_INSERT);
                nm_reg     <= slope;
                nb_reg     <= intercept;
                best_reg   <= lsmq_pkg::S64_MIN;
                step_reg   <= PT_MID;
                which_reg  <= 1'b0;
                swap_reg   <= 1'b0;
            end
            lsmq_pkg::ST_NODE:
            begin
                step_reg  <= PT_MID;
                which_reg <= 1'b0;
                swap_reg  <= 1'b0;
            end
            lsmq_pkg::ST_XADDR:
            begin
                // node line arrives from the store on the first test of a level
                if (step_reg == PT_MID)
                begin
                    cm_reg <= nrd_m_reg;
                    cb_reg <= nrd_b_reg;
                end
            end
            lsmq_pkg::ST_MUL:
                prod_reg <= 64'(which_reg ? nm_reg : cm_reg) * 64'(x_reg);
            lsmq_pkg::ST_ADD:
            begin
                if (!is_ins_reg)
                begin
                    if (val > best_reg)
                        best_reg <= val;
                end
                else if (!which_reg)
                begin
                    vc_reg    <= val;
                    which_reg <= 1'b1;
                end
            end
            lsmq_pkg::ST_CMP:
            begin
                which_reg <= 1'b0;
                if (step_reg == PT_MID)
                begin
                    step_reg <= PT_LO;
                    if (vc_reg < val)
                    begin
                        // winner stays at node, loser carries on (dropped at a leaf)
                        cm_reg   <= nm_reg;
                        cb_reg   <= nb_reg;
                        nm_reg   <= cm_reg;
                        nb_reg   <= cb_reg;
                        swap_reg <= 1'b1;
                    end
                end
                else if (vc_reg < val)
                    step_reg <= PT_DESC;
                else
                    step_reg <= PT_HI;
            end
            lsmq_pkg::ST_WRITE:
            begin
                // write back the staying line (swap: cm/cb hold it, nm/nb hold loser)
                swap_reg <= 1'b0;
                if (step_reg == PT_DESC && !leaf)
                begin
                    if (cmp_left_reg)
                    begin
                        node_reg <= {node_reg[NW-2:0], 1'b0};
                        hi_reg   <= mid;
                    end
                    else
                    begin
                        node_reg <= {node_reg[NW-2:0], 1'b1};
                        lo_reg   <= mid + IW'(1);
                    end
                end
            end
            lsmq_pkg::ST_OUT:
                out_reg <= best_reg;
            default:
            begin
            end
        endcase
        if (state_reg == lsmq_pkg::ST_ADD && !is_ins_reg && !leaf)
        begin
            if (pos_reg <= mid)
            begin
                node_reg <= {node_reg[NW-2:0], 1'b0};
                hi_reg   <= mid;
            end
            else
            begin
                node_reg <= {node_reg[NW-2:0], 1'b1};
                lo_reg   <= mid + IW'(1);
            end
        end
    end

    // remembers whether the lo test won (left descent)
    always_ff @(posedge clk)
    begin
        if (state_reg == lsmq_pkg::ST_CMP)
            cmp_left_reg <= (step_reg == PT_LO) && (vc_reg < val);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lsmq_pkg::ST_CLEAR:
                if (clr_reg == NW'(NODES - 1))
                    state_next = lsmq_pkg::ST_IDLE;
            lsmq_pkg::ST_IDLE:
                if (in_valid && !in_stall)
                begin
                    if (op == lsmq_pkg::OP_INSERT || op == lsmq_pkg::OP_QUERY)
                        state_next = lsmq_pkg::ST_NODE;
                end
            lsmq_pkg::ST_NODE:
                state_next = lsmq_pkg::ST_XADDR;
            lsmq_pkg::ST_XADDR:
                state_next = lsmq_pkg::ST_XWAIT;
            lsmq_pkg::ST_XWAIT:
                state_next = lsmq_pkg::ST_MUL;
            lsmq_pkg::ST_MUL:
                state_next = lsmq_pkg::ST_ADD;
            lsmq_pkg::ST_ADD:
            begin
                if (!is_ins_reg)
                    state_next = leaf ? lsmq_pkg::ST_OUT : lsmq_pkg::ST_NODE;
                else if (!which_reg)
                    state_next = lsmq_pkg::ST_MUL;
                else
                    state_next = lsmq_pkg::ST_CMP;
            end
            lsmq_pkg::ST_CMP:
            begin
                if (step_reg == PT_MID && leaf)
                    state_next = lsmq_pkg::ST_WRITE;
                else if (step_reg == PT_MID)
                    state_next = lsmq_pkg::ST_XADDR;
                else if (step_reg == PT_LO && !(vc_reg < val))
                    state_next = lsmq_pkg::ST_XADDR;
                else
                    state_next = lsmq_pkg::ST_WRITE;
            end
            lsmq_pkg::ST_WRITE:
            begin
                if (leaf || step_reg != PT_DESC)
                    state_next = lsmq_pkg::ST_IDLE;
                else
                    state_next = lsmq_pkg::ST_NODE;
            end
            lsmq_pkg::ST_OUT:
                state_next = lsmq_pkg::ST_IDLE;
            default:
                state_next = lsmq_pkg::ST_IDLE;
        endcase
    end

endmodule

// File: rtl/lsmq_checker.sv
// lsmq_checker: port-level assertions for line_set_max_query_tree_core
// bound into line_set_max_query_tree_core; no package use
module lsmq_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [63:0] max_value
);

    // a waiting result holds its value
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(max_value))
        else $error("result changed while stalled");

    // no new transaction while a result waits
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input taken with result pending");

    // a result appears only if the block was busy before
    a_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result without work");

endmodule

bind line_set_max_query_tree_core lsmq_checker u_lsmq_checker (
    .clk(clk), .rst_n(rst_n), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .max_value(max_value)
);

// File: test/lsmq_max_checker.sv
// lsmq_max_checker: watches the line set max query tree channels, predicts each query and compares
// depends on lsmq_pkg for the op codes and the saturation bounds
module lsmq_max_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [1:0]         op,
    input  logic [9:0]         index,
    input  logic signed [31:0] coord_value,
    input  logic signed [31:0] slope,
    input  logic signed [63:0] intercept,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic signed [63:0] max_value,
    input  logic               cfg_we,
    input  logic [10:0]        cfg_wdata,
    output int                 fails,
    output int                 pending
);

    localparam int NODES = 4 * lsmq_pkg::MAX_COORDS_DEF;

    logic signed [31:0] x_table [lsmq_pkg::MAX_COORDS_DEF];
    logic signed [31:0] node_m [NODES];
    logic signed [63:0] node_b [NODES];
    logic [10:0]        coord_count;
    logic signed [63:0] expected_max_q [$];

    // y = m*x + b at coordinate pos, saturated
    function automatic logic signed [63:0] line_y(input logic signed [31:0] m,
                                                  input logic signed [63:0] b,
                                                  input int pos);
        longint p;
        logic signed [64:0] s;
        p = longint'(m) * longint'(x_table[pos]);
        s = {p[63], p} + {b[63], b};
        if (s[64] != s[63])
            return s[64] ? lsmq_pkg::S64_MIN : lsmq_pkg::S64_MAX;
        return s[63:0];
    endfunction

    function automatic int span_last();
        int n;
        n = coord_count;
        if (n < 1)
            n = 1;
        if (n > lsmq_pkg::MAX_COORDS_DEF)
            n = lsmq_pkg::MAX_COORDS_DEF;
        return n - 1;
    endfunction

    task automatic add_line(input logic signed [31:0] m_in, input logic signed [63:0] b_in);
        int u, l, r, mid;
        logic signed [31:0] m, cm;
        logic signed [63:0] b, cb;
        u = 1;
        l = 0;
        r = span_last();
        m = m_in;
        b = b_in;
        while (u < NODES)
        begin
            cm = node_m[u];
            cb = node_b[u];
            if (l == r)
            begin
                if (line_y(cm, cb, l) < line_y(m, b, l))
                begin
                    node_m[u] = m;
                    node_b[u] = b;
                end
                return;
            end
            mid = (l + r) / 2;
            if (line_y(cm, cb, mid) < line_y(m, b, mid))
            begin
                node_m[u] = m;
                node_b[u] = b;
                m = cm;
                b = cb;
                cm = node_m[u];
                cb = node_b[u];
            end
            if (line_y(cm, cb, l) < line_y(m, b, l))
            begin
                u = 2 * u;
                r = mid;
            end
            else if (line_y(cm, cb, r) < line_y(m, b, r))
            begin
                u = 2 * u + 1;
                l = mid + 1;
            end
            else
                return;
        end
    endtask

    function automatic logic signed [63:0] best_at(input int pos_in);
        int u, l, r, mid, pos;
        logic signed [63:0] best, v;
        u = 1;
        l = 0;
        r = span_last();
        pos = (pos_in > r) ? r : pos_in;
        best = lsmq_pkg::S64_MIN;
        while (u < NODES)
        begin
            v = line_y(node_m[u], node_b[u], pos);
            if (v > best)
                best = v;
            if (l == r)
                break;
            mid = (l + r) / 2;
            if (pos <= mid)
            begin
                u = 2 * u;
                r = mid;
            end
            else
            begin
                u = 2 * u + 1;
                l = mid + 1;
            end
        end
        return best;
    endfunction

    task automatic report_mismatch(input string what, input logic signed [63:0] got,
                                   input logic signed [63:0] want);
        $display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
        fails++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (x_table[i])
                x_table[i] = '0;
            foreach (node_m[i])
            begin
                node_m[i] = '0;
                node_b[i] = '0;
            end
            coord_count = 11'(lsmq_pkg::MAX_COORDS_DEF);
            expected_max_q.delete();
            fails = 0;
            pending = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_max_q.size() == 0)
                    report_mismatch("unexpected result max_value", max_value, 'x);
                else if (max_value !== expected_max_q[0])
                    report_mismatch("max_value", max_value, expected_max_q.pop_front());
                else
                    void'(expected_max_q.pop_front());
            end
            if (in_valid && !in_stall)
            begin
                case (op)
                    lsmq_pkg::OP_LOAD:   x_table[index] = coord_value;
                    lsmq_pkg::OP_INSERT: add_line(slope, intercept);
                    lsmq_pkg::OP_QUERY:
                        expected_max_q = {expected_max_q, best_at(int'(index))};
                    default: ;
                endcase
            end
            if (cfg_we)
                coord_count = cfg_wdata;
            pending = expected_max_q.size();
        end
    end

endmodule

// File: test/tb.sv
// tb: stimulus and verdict for line_set_max_query_tree_core
// depends on lsmq_pkg, the core and lsmq_max_checker
module tb;

    // generous: covers the longest inserts, plus gaps, stalls and phase pauses
    localparam int CYCLE_LIMIT = 1500000;
    // longest transaction latency plus margin
    localparam int DRAIN_CYCLES = 300;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [1:0]         op;
    logic [9:0]         index;
    logic signed [31:0] coord_value;
    logic signed [31:0] slope;
    logic signed [63:0] intercept;
    logic               out_valid;
    logic               out_stall;
    logic signed [63:0] max_value;
    logic               cfg_we;
    logic [10:0]        cfg_wdata;

    int fails;
    int pending;
    int cycle_count;
    int ostall_left;
    int count_now;
    bit quiet;

    line_set_max_query_tree_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .index       (index),
        .coord_value (coord_value),
        .slope       (slope),
        .intercept   (intercept),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .max_value   (max_value),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata)
    );

    lsmq_max_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .index       (index),
        .coord_value (coord_value),
        .slope       (slope),
        .intercept   (intercept),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .max_value   (max_value),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .fails       (fails),
        .pending     (pending)
    );

    always #5 clk = ~clk;

    // watchdog: a hung handshake ends the run here
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("** line_set_max_query_tree_core: FAILED **");
            $finish;
        end
    end

    // receiver back-pressure in random bursts, none when quiet
    always @(posedge clk)
    begin
        if (quiet)
            out_stall <= 1'b0;
        else if (ostall_left > 0)
        begin
            ostall_left--;
            out_stall <= 1'b1;
        end
        else if ($urandom_range(0, 7) == 0)
        begin
            ostall_left = $urandom_range(1, 6) - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // one transaction: optional idle burst first, then hold until accepted
    task automatic put_item(input logic [1:0] o, input logic [9:0] i,
                            input logic signed [31:0] cv, input logic signed [31:0] sl,
                            input logic signed [63:0] ic);
        int gap;
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 6);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        op          <= o;
        index       <= i;
        coord_value <= cv;
        slope       <= sl;
        intercept   <= ic;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // sender holds off until every query has answered and the core has gone idle
    task automatic settle();
        in_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_count(input logic [10:0] v);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
        count_now = (v == 0) ? 1 : (v > lsmq_pkg::MAX_COORDS_DEF) ? lsmq_pkg::MAX_COORDS_DEF
                                                                   : int'(v);
    endtask

    // ascending table over the full Q16.16 range, both extremes included
    task automatic load_wide();
        longint v;
        for (int i = 0; i < lsmq_pkg::MAX_COORDS_DEF; i++)
        begin
            if (i == 0)
                v = -64'sd2147483648;
            else if (i == lsmq_pkg::MAX_COORDS_DEF - 1)
                v = 64'sd2147483647;
            else
                v = -64'sd2147483648 + longint'(i) * 4194304 + $urandom_range(0, 4194303);
            put_item(lsmq_pkg::OP_LOAD, 10'(i), 32'(v), '0, '0);
        end
    endtask

    // ascending table packed around zero so that lines cross often
    task automatic load_narrow(input int n);
        longint step, v;
        step = $urandom_range(1, 65536);
        for (int i = 0; i < n; i++)
        begin
            v = (longint'(i) - n / 2) * step;
            put_item(lsmq_pkg::OP_LOAD, 10'(i), 32'(v), 32'($urandom),
                     64'({$urandom, $urandom}));
        end
    endtask

    function automatic logic signed [31:0] pick_slope();
        case ($urandom_range(0, 9))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7FFF_FFFF;
            2, 3:    return 32'($urandom);
            default: return 32'(longint'($urandom_range(0, 2097152)) - 1048576);
        endcase
    endfunction

    function automatic logic signed [63:0] pick_intercept();
        case ($urandom_range(0, 9))
            0:       return lsmq_pkg::S64_MIN;
            1:       return lsmq_pkg::S64_MAX;
            2, 3:    return {$urandom, $urandom};
            default: return (longint'($urandom_range(0, 1048576)) - 524288) <<< 32;
        endcase
    endfunction

    // mixed random transactions: inserts and queries dominate
    task automatic run_phase(input int n_items);
        int r;
        logic [9:0] qi;
        for (int k = 0; k < n_items; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 45)
                put_item(lsmq_pkg::OP_INSERT, 10'($urandom), 32'($urandom), pick_slope(),
                         pick_intercept());
            else if (r < 85)
            begin
                // mostly inside the span, sometimes clamped from above
                qi = ($urandom_range(0, 4) == 0) ? 10'($urandom)
                                                 : 10'($urandom_range(0, count_now - 1));
                put_item(lsmq_pkg::OP_QUERY, qi, 32'($urandom), 32'($urandom),
                         64'({$urandom, $urandom}));
            end
            else if (r < 95)
                put_item(lsmq_pkg::OP_LOAD, 10'($urandom), 32'($urandom), 32'($urandom),
                         64'({$urandom, $urandom}));
            else
                // unused op, must be ignored
                put_item(lsmq_pkg::OP_UNUSED, 10'($urandom), 32'($urandom), 32'($urandom),
                         64'({$urandom, $urandom}));
        end
    endtask

    int phase_counts [10] = '{1, 0, 2, 3, 7, 1000, 2047, 513, 64, 1024};

    initial
    begin
        clk         = 1'b0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        op          = lsmq_pkg::OP_LOAD;
        index       = '0;
        coord_value = '0;
        slope       = '0;
        intercept   = '0;
        out_stall   = 1'b0;
        cfg_we      = 1'b0;
        cfg_wdata   = '0;
        quiet       = 1'b0;
        cycle_count = 0;
        ostall_left = 0;
        count_now   = lsmq_pkg::MAX_COORDS_DEF;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        // clearing pass of the node store
        repeat (2 * lsmq_pkg::MAX_COORDS_DEF + 20) @(posedge clk);

        write_count(11'(lsmq_pkg::MAX_COORDS_DEF));
        load_wide();

        // directed: empty tree, extreme lines, saturation both ways, ties, unused op
        put_item(lsmq_pkg::OP_QUERY, 10'd0, '0, '0, '0);
        put_item(lsmq_pkg::OP_INSERT, '0, '0, 32'sh7FFF_FFFF, lsmq_pkg::S64_MAX);
        put_item(lsmq_pkg::OP_QUERY, 10'd1023, '0, '0, '0);
        put_item(lsmq_pkg::OP_INSERT, '0, '0, 32'sh8000_0000, lsmq_pkg::S64_MIN);
        put_item(lsmq_pkg::OP_QUERY, 10'd0, '0, '0, '0);
        put_item(lsmq_pkg::OP_INSERT, '0, '0, 32'sh8000_0000, lsmq_pkg::S64_MAX);
        put_item(lsmq_pkg::OP_QUERY, 10'd0, '0, '0, '0);
        put_item(lsmq_pkg::OP_QUERY, 10'd511, '0, '0, '0);
        put_item(lsmq_pkg::OP_INSERT, '0, '0, 32'sh0001_0000, 64'sd5 <<< 32);
        put_item(lsmq_pkg::OP_INSERT, '0, '0, 32'sh0001_0000, 64'sd5 <<< 32);
        put_item(lsmq_pkg::OP_QUERY, 10'd512, '0, '0, '0);
        put_item(lsmq_pkg::OP_UNUSED, 10'd1023, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                 lsmq_pkg::S64_MAX);
        put_item(lsmq_pkg::OP_QUERY, 10'd1023, '0, '0, '0);

        // configurations from one coordinate up to past the top, tree kept across them
        foreach (phase_counts[p])
        begin
            write_count(11'(phase_counts[p]));
            if (p == 9)
                quiet = 1'b1;
            if (count_now <= 64 && $urandom_range(0, 1) == 1)
                load_narrow(count_now);
            run_phase(85);
        end

        settle();
        if (fails == 0 && pending == 0)
            $display("** line_set_max_query_tree_core: PASSED **");
        else
            $display("** line_set_max_query_tree_core: FAILED **");
        $finish;
    end

endmodule
